### sv/phist_pkg.sv
package phist_pkg;

  // Default sizing of the histogram
  localparam int NUM_BINS_DEF   = 256;
  localparam int COUNT_BITS_DEF = 32;

  // Field widths
  localparam int OP_BITS    = 2;
  localparam int VALUE_BITS = 8;
  localparam int PLOT_BITS  = 13;
  localparam int BAR_BITS   = 12;
  localparam int OUT_BITS   = 32;

  // Bar scaling: quotient is at most plot_height - 1, so PLOT_BITS bits
  localparam int QUOT_BITS = PLOT_BITS;
  localparam int STEP_BITS = $clog2(QUOT_BITS);

  localparam logic [PLOT_BITS-1:0] PLOT_HEIGHT_RESET = PLOT_BITS'(400);

  typedef enum logic [OP_BITS-1:0] {
    OP_COUNT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_CALC,
    ST_OUT
  } state_t;

  // Item held in the read-modify-write stage
  typedef struct packed {
    logic                  vld;
    logic [OP_BITS-1:0]    op;
    logic [VALUE_BITS-1:0] value;
  } stage_t;

endpackage

### sv/phist_ram.sv
module phist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; a read at the written address sees old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/phist_div.sv
module phist_div #(
  parameter int COUNT_BITS = phist_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [COUNT_BITS-1:0]           count,
  input  logic [COUNT_BITS-1:0]           largest,
  input  logic [phist_pkg::PLOT_BITS-1:0] span,
  output logic                            done,
  output logic [phist_pkg::QUOT_BITS-1:0] quot
);

  localparam int QB = phist_pkg::QUOT_BITS;
  localparam int PW = COUNT_BITS + phist_pkg::PLOT_BITS;

  logic                            mul_r;
  logic                            run_r;
  logic                            done_r;
  logic [phist_pkg::STEP_BITS-1:0] step_r;
  logic [COUNT_BITS-1:0]           cnt_r;
  logic [COUNT_BITS-1:0]           den_r;
  logic [phist_pkg::PLOT_BITS-1:0] span_r;
  logic [COUNT_BITS-1:0]           rem_r;
  logic [QB-1:0]                   low_r;
  logic [QB-1:0]                   quot_r;

  logic [PW-1:0]         prod;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  fits;

  // Product count * span; count never exceeds largest, so the quotient fits QB bits
  assign prod  = PW'(cnt_r) * PW'(span_r);
  assign trial = {rem_r, low_r[QB-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  // Control: the multiply step, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        mul_r <= 1'b1;
      end else if (mul_r) begin
        mul_r <= 1'b0;
        run_r <= 1'b1;
      end else if (run_r && step_r == '0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: restoring division of the product by the largest count
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= count;
      den_r  <= largest;
      span_r <= span;
    end else if (mul_r) begin
      rem_r  <= prod[PW-1:QB];
      low_r  <= prod[QB-1:0];
      quot_r <= '0;
      step_r <= phist_pkg::STEP_BITS'(QB - 1);
    end else if (run_r) begin
      rem_r  <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      low_r  <= {low_r[QB-2:0], 1'b0};
      quot_r <= {quot_r[QB-2:0], fits};
      step_r <= step_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

### sv/pixel_histogram_with_bar_heights.sv
// Grayscale pixel histogram with bar heights.
// Input: an item (in_opcode, in_value) transfers at a rising edge with start high and
// busy low. COUNT adds one pixel to bin in_value, READ returns bin in_value, CLEAR
// zeroes every bin and the largest count; opcode 3 and pixels beyond the bins are dropped.
// Config: cfg_data (plot_height) transfers when cfg_valid and cfg_ready are high;
// cfg_ready is always high; the user makes writes while the block is idle (not enforced).
// Output: a READ result is shown for one cycle with out_valid high: out_bin_count,
// out_bar_height = floor(count*(plot_height-1)/largest) capped at 4095, and
// out_largest_count. The receiver cannot stall; each result is taken as it appears.
// Throughput: COUNT and CLEAR are taken back to back, one per cycle; the bin memory is
// read at transfer and written in the cycle after, with a forward path for repeats of the
// same bin. READ keeps busy high up to and including its out_valid cycle; the result
// follows one memory read, one multiply, then one quotient bit per cycle for 13 bits.
// Reset: synchronous on rst_n low; all bins read as zero at once (per-bin valid flags),
// largest count is zero and plot_height is 400. No clearing pass is needed.
module pixel_histogram_with_bar_heights #(
  parameter int NUM_BINS   = phist_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS = phist_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [phist_pkg::OP_BITS-1:0]    in_opcode,
  input  logic [phist_pkg::VALUE_BITS-1:0] in_value,
  output logic                             out_valid,
  output logic [phist_pkg::OUT_BITS-1:0]   out_bin_count,
  output logic [phist_pkg::BAR_BITS-1:0]   out_bar_height,
  output logic [phist_pkg::OUT_BITS-1:0]   out_largest_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [phist_pkg::PLOT_BITS-1:0]  cfg_data
);

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int OB = phist_pkg::OUT_BITS;
  localparam int PB = phist_pkg::PLOT_BITS;

  phist_pkg::state_t state_r, state_nxt;
  phist_pkg::stage_t s1_r, s1_nxt;

  logic [NUM_BINS-1:0]   vld_r, vld_nxt;
  logic [COUNT_BITS-1:0] max_r, max_nxt;
  logic [PB-1:0]         plot_r;
  logic                  fwd_vld_r, fwd_vld_nxt;
  logic [AW-1:0]         fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_data_r;
  logic                  zero_r;
  logic [OB-1:0]         bin_r;
  logic [OB-1:0]         largest_r;
  logic [phist_pkg::BAR_BITS-1:0] bar_r;

  logic                  accept;
  logic                  s1_read;
  logic                  div_start;
  logic                  div_done;
  logic [phist_pkg::QUOT_BITS-1:0] div_quot;
  logic [AW-1:0]         raddr;
  logic [AW-1:0]         s1_addr;
  logic                  s1_in_range;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] old_count;
  logic [COUNT_BITS-1:0] new_count;
  logic [COUNT_BITS-1:0] read_count;
  logic                  ram_we;
  logic [PB-1:0]         span;

  function automatic logic [OB-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] hi;
    hi = v >> OB;
    sat_out = (hi != '0) ? '1 : OB'(v);
  endfunction

  assign accept      = start && !busy;
  assign raddr       = AW'(in_value);
  assign s1_addr     = AW'(s1_r.value);
  assign s1_in_range = (PB'(s1_r.value) < PB'(NUM_BINS));
  assign s1_read     = s1_r.vld && (s1_r.op == phist_pkg::OP_READ);
  assign span        = (plot_r < PB'(2)) ? '0 : plot_r - 1'b1;

  phist_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (new_count),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // Old count: forward the write made at the read edge, else memory gated by valid flag
  always_comb begin
    if (fwd_vld_r && fwd_addr_r == s1_addr) begin
      old_count = fwd_data_r;
    end else if (vld_r[s1_addr]) begin
      old_count = ram_rdata;
    end else begin
      old_count = '0;
    end
  end

  assign new_count  = (old_count == '1) ? old_count : old_count + 1'b1;
  assign read_count = s1_in_range ? old_count : '0;

  // Read-modify-write stage
  always_comb begin
    vld_nxt     = vld_r;
    max_nxt     = max_r;
    fwd_vld_nxt = 1'b0;
    ram_we      = 1'b0;
    if (s1_r.vld) begin
      case (s1_r.op)
        phist_pkg::OP_COUNT: begin
          if (s1_in_range) begin
            ram_we           = 1'b1;
            fwd_vld_nxt      = 1'b1;
            vld_nxt[s1_addr] = 1'b1;
            if (new_count > max_r) begin
              max_nxt = new_count;
            end
          end
        end
        phist_pkg::OP_CLEAR: begin
          vld_nxt = '0;
          max_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Advance the item into the stage
  always_comb begin
    s1_nxt       = s1_r;
    s1_nxt.vld   = accept;
    if (accept) begin
      s1_nxt.op    = in_opcode;
      s1_nxt.value = in_value;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      phist_pkg::ST_RUN:  if (s1_read) state_nxt = phist_pkg::ST_CALC;
      phist_pkg::ST_CALC: if (div_done) state_nxt = phist_pkg::ST_OUT;
      phist_pkg::ST_OUT:  state_nxt = phist_pkg::ST_RUN;
      default:            state_nxt = phist_pkg::ST_RUN;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    busy      = s1_read;
    out_valid = 1'b0;
    div_start = 1'b0;
    case (state_r)
      phist_pkg::ST_RUN: div_start = s1_read;
      phist_pkg::ST_CALC: busy = 1'b1;
      phist_pkg::ST_OUT: begin
        busy      = 1'b1;
        out_valid = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= phist_pkg::ST_RUN;
      s1_r      <= '0;
      vld_r     <= '0;
      max_r     <= '0;
      fwd_vld_r <= 1'b0;
      plot_r    <= phist_pkg::PLOT_HEIGHT_RESET;
    end else begin
      state_r   <= state_nxt;
      s1_r      <= s1_nxt;
      vld_r     <= vld_nxt;
      max_r     <= max_nxt;
      fwd_vld_r <= fwd_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        plot_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fwd_addr_r <= s1_addr;
    fwd_data_r <= new_count;
    if (div_start) begin
      bin_r     <= sat_out(read_count);
      largest_r <= sat_out(max_r);
      zero_r    <= (max_r == '0) || (plot_r < PB'(2));
    end
    if (div_done) begin
      if (zero_r) begin
        bar_r <= '0;
      end else if (div_quot[phist_pkg::QUOT_BITS-1]) begin
        bar_r <= '1;
      end else begin
        bar_r <= div_quot[phist_pkg::BAR_BITS-1:0];
      end
    end
  end

  phist_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .count   (read_count),
    .largest (max_r),
    .span    (span),
    .done    (div_done),
    .quot    (div_quot)
  );

  assign cfg_ready         = 1'b1;
  assign out_bin_count     = bin_r;
  assign out_bar_height    = bar_r;
  assign out_largest_count = largest_r;

  // A result strobe lasts one cycle
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held for more than one cycle");

  // An accepted read blocks the next transfer
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == phist_pkg::OP_READ) |=> busy)
    else $error("read accepted without raising busy");

  // The largest count covers every count written back
  a_max_cover: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (max_r >= $past(new_count)))
    else $error("largest count below a written bin count");

  // The divider finishes only while a read waits for it
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == phist_pkg::ST_CALC))
    else $error("divider finished outside a read");

endmodule

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [phist_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam int BINS              = phist_pkg::NUM_BINS_DEF;
  localparam int SETTLE_CYCLES     = 24;
  localparam int CYCLE_LIMIT       = 400000;
  localparam int ITEMS_PER_SETTING = 112;

  typedef struct packed {
    logic [phist_pkg::OUT_BITS-1:0] bin_count;
    logic [phist_pkg::BAR_BITS-1:0] bar_height;
    logic [phist_pkg::OUT_BITS-1:0] largest_count;
  } bin_reading_t;

  typedef struct {
    logic [phist_pkg::OP_BITS-1:0]    op;
    logic [phist_pkg::VALUE_BITS-1:0] value;
    bit                               typed;
    bin_reading_t                     reading;
  } stim_row_t;

  logic                             clk;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  logic [phist_pkg::OP_BITS-1:0]    in_opcode;
  logic [phist_pkg::VALUE_BITS-1:0] in_value;
  logic                             out_valid;
  logic [phist_pkg::OUT_BITS-1:0]   out_bin_count;
  logic [phist_pkg::BAR_BITS-1:0]   out_bar_height;
  logic [phist_pkg::OUT_BITS-1:0]   out_largest_count;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [phist_pkg::PLOT_BITS-1:0]  cfg_data;

  // Histogram mirror: bins, peak count and plot height
  logic [phist_pkg::COUNT_BITS_DEF-1:0] hist_bins [BINS];
  logic [phist_pkg::COUNT_BITS_DEF-1:0] hist_peak;
  logic [phist_pkg::PLOT_BITS-1:0]      plot_h;

  bin_reading_t pending_reads [$];
  stim_row_t    directed_rows [$];
  logic [phist_pkg::VALUE_BITS-1:0] hot_bins [4];

  bit no_idle;
  int mismatches;
  int cycle_count;
  int pixels_sent;
  int reads_checked;
  int clears_sent;
  int settings_used;

  pixel_histogram_with_bar_heights i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_bin_count    (out_bin_count),
    .out_bar_height   (out_bar_height),
    .out_largest_count(out_largest_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Scale a count against the peak, exact integer divide, capped
  function automatic logic [phist_pkg::BAR_BITS-1:0] bar_for(
      logic [phist_pkg::COUNT_BITS_DEF-1:0] cnt);
    logic [63:0] h;
    if (hist_peak == '0 || plot_h < 2) return '0;
    h = (64'(cnt) * (64'(plot_h) - 64'd1)) / 64'(hist_peak);
    return (h > 64'd4095) ? 12'hFFF : h[phist_pkg::BAR_BITS-1:0];
  endfunction

  // Apply one item to the mirror; return 1 when it yields a reading
  function automatic bit histogram_step(input logic [phist_pkg::OP_BITS-1:0] op,
                                        input logic [phist_pkg::VALUE_BITS-1:0] value,
                                        output bin_reading_t rd);
    logic [phist_pkg::COUNT_BITS_DEF-1:0] c;
    rd = '0;
    case (op)
      phist_pkg::OP_COUNT: begin
        if (int'(value) < BINS) begin
          c = hist_bins[value];
          if (c != '1) c = c + 1'b1;
          hist_bins[value] = c;
          if (c > hist_peak) hist_peak = c;
        end
      end
      phist_pkg::OP_READ: begin
        c = (int'(value) < BINS) ? hist_bins[value] : '0;
        rd.bin_count     = c;
        rd.bar_height    = bar_for(c);
        rd.largest_count = hist_peak;
        return 1'b1;
      end
      phist_pkg::OP_CLEAR: begin
        for (int i = 0; i < BINS; i++) hist_bins[i] = '0;
        hist_peak = '0;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly hit a few hot bins, skewed, so bar heights spread out
  function automatic logic [phist_pkg::VALUE_BITS-1:0] pick_bin();
    if ($urandom_range(0, 99) < 70) return hot_bins[$urandom_range(0, 3) & $urandom_range(0, 3)];
    return phist_pkg::VALUE_BITS'($urandom_range(0, 255));
  endfunction

  task automatic flag_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic add_row(input logic [phist_pkg::OP_BITS-1:0] op,
                         input logic [phist_pkg::VALUE_BITS-1:0] value,
                         input bit typed, input logic [phist_pkg::OUT_BITS-1:0] bc,
                         input logic [phist_pkg::BAR_BITS-1:0] bh,
                         input logic [phist_pkg::OUT_BITS-1:0] lc);
    stim_row_t row;
    row.op      = op;
    row.value   = value;
    row.typed   = typed;
    row.reading = '{bin_count: bc, bar_height: bh, largest_count: lc};
    directed_rows.push_back(row);
  endtask

  // Present one item, hold it until it transfers, then predict
  task automatic send_item(input logic [phist_pkg::OP_BITS-1:0] op,
                           input logic [phist_pkg::VALUE_BITS-1:0] value,
                           input bit typed, input bin_reading_t typed_rd);
    int           gap;
    bin_reading_t rd;
    bit           has_rd;
    gap = pick_gap();
    if (gap > 0) begin
      start     <= 1'b0;
      in_opcode <= phist_pkg::OP_BITS'($urandom);
      in_value  <= phist_pkg::VALUE_BITS'($urandom);
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_opcode <= op;
    in_value  <= value;
    do @(posedge clk); while (busy);
    has_rd = histogram_step(op, value, rd);
    if (has_rd) pending_reads.push_back(typed ? typed_rd : rd);
    if (op == phist_pkg::OP_COUNT) pixels_sent++;
    if (op == phist_pkg::OP_CLEAR) clears_sent++;
  endtask

  // Drain, let the pipeline settle, then write plot_height
  task automatic write_plot_height(input logic [phist_pkg::PLOT_BITS-1:0] height);
    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= height;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    plot_h = height;
    settings_used++;
  endtask

  // Compare each reading with the oldest prediction
  always @(posedge clk) begin : check_readings
    bin_reading_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_reads.size() == 0) begin
        flag_mismatch($sformatf("reading with none pending: count=%0d", out_bin_count));
      end else begin
        want = pending_reads.pop_front();
        if (out_bin_count !== want.bin_count)
          flag_mismatch($sformatf("bin_count %0d, want %0d", out_bin_count, want.bin_count));
        if (out_bar_height !== want.bar_height)
          flag_mismatch($sformatf("bar_height %0d, want %0d", out_bar_height, want.bar_height));
        if (out_largest_count !== want.largest_count)
          flag_mismatch($sformatf("largest_count %0d, want %0d", out_largest_count,
                                  want.largest_count));
        reads_checked++;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[pixel_histogram_with_bar_heights] ERROR");
      $finish;
    end
  end

  initial begin
    logic [phist_pkg::PLOT_BITS-1:0]  heights [$];
    logic [phist_pkg::OP_BITS-1:0]    op;
    logic [phist_pkg::VALUE_BITS-1:0] value;
    int r;
    int done;
    int n;

    start     <= 1'b0;
    in_opcode <= '0;
    in_value  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    no_idle    = 1'b0;
    for (int i = 0; i < BINS; i++) hist_bins[i] = '0;
    hist_peak = '0;
    plot_h    = phist_pkg::PLOT_HEIGHT_RESET;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, unused opcode, small counts, repeats, clears
    add_row(phist_pkg::OP_READ,  8'h00, 1, 0, 0, 0);
    add_row(phist_pkg::OP_READ,  8'hFF, 1, 0, 0, 0);
    add_row(OP_UNUSED,           8'hFF, 0, 0, 0, 0);
    add_row(OP_UNUSED,           8'h00, 0, 0, 0, 0);
    add_row(phist_pkg::OP_READ,  8'hFF, 1, 0, 0, 0);
    add_row(phist_pkg::OP_COUNT, 8'h00, 0, 0, 0, 0);
    add_row(phist_pkg::OP_READ,  8'h00, 1, 1, 399, 1);
    add_row(phist_pkg::OP_COUNT, 8'hFF, 0, 0, 0, 0);
    add_row(phist_pkg::OP_COUNT, 8'hFF, 0, 0, 0, 0);
    add_row(phist_pkg::OP_READ,  8'hFF, 1, 2, 399, 2);
    add_row(phist_pkg::OP_READ,  8'h00, 1, 1, 199, 2);
    add_row(phist_pkg::OP_READ,  8'h80, 1, 0, 0, 2);
    add_row(phist_pkg::OP_COUNT, 8'hAA, 0, 0, 0, 0);
    add_row(phist_pkg::OP_COUNT, 8'h55, 0, 0, 0, 0);
    add_row(phist_pkg::OP_COUNT, 8'h55, 0, 0, 0, 0);
    add_row(phist_pkg::OP_COUNT, 8'h55, 0, 0, 0, 0);
    add_row(phist_pkg::OP_READ,  8'h55, 1, 3, 399, 3);
    add_row(phist_pkg::OP_READ,  8'hAA, 0, 0, 0, 0);
    add_row(phist_pkg::OP_CLEAR, 8'h00, 0, 0, 0, 0);
    add_row(phist_pkg::OP_READ,  8'h55, 1, 0, 0, 0);
    add_row(phist_pkg::OP_COUNT, 8'h55, 0, 0, 0, 0);
    add_row(phist_pkg::OP_CLEAR, 8'hFF, 0, 0, 0, 0);
    add_row(phist_pkg::OP_COUNT, 8'h0F, 0, 0, 0, 0);
    add_row(phist_pkg::OP_READ,  8'h0F, 1, 1, 399, 1);
    add_row(phist_pkg::OP_READ,  8'h55, 1, 0, 0, 1);
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
                directed_rows[i].reading);

    // Plot heights: smallest legal, full width, zero, one, top of range, mid values
    heights.push_back(13'd2);
    heights.push_back(13'd8191);
    heights.push_back(13'd0);
    heights.push_back(13'd1);
    heights.push_back(13'd4096);
    heights.push_back(phist_pkg::PLOT_BITS'($urandom_range(2, 4096)));
    heights.push_back(13'd400);
    heights.push_back(phist_pkg::PLOT_BITS'($urandom_range(0, 8191)));

    // Random traffic under each plot height
    foreach (heights[h]) begin
      write_plot_height(heights[h]);
      foreach (hot_bins[k]) hot_bins[k] = phist_pkg::VALUE_BITS'($urandom_range(0, 255));
      done = 0;
      n = 0;
      while (done < ITEMS_PER_SETTING) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        n++;
        r = $urandom_range(0, 99);
        if (r < 55) begin
          op    = phist_pkg::OP_COUNT;
          value = pick_bin();
        end else if (r < 90) begin
          op    = phist_pkg::OP_READ;
          value = pick_bin();
        end else if (r < 93) begin
          op    = phist_pkg::OP_CLEAR;
          value = phist_pkg::VALUE_BITS'($urandom_range(0, 255));
        end else begin
          op    = OP_UNUSED;
          value = phist_pkg::VALUE_BITS'($urandom_range(0, 255));
        end
        send_item(op, value, 1'b0, '0);
        if (op != OP_UNUSED) done++;
      end
    end

    // Drain and report
    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d bin readings against %0d pixels and %0d clears,",
             reads_checked, pixels_sent, clears_sent);
    $display("over %0d plot height settings plus the reset value.", settings_used);
    if (mismatches == 0) begin
      $display("[pixel_histogram_with_bar_heights] OK");
    end else begin
      $display("[pixel_histogram_with_bar_heights] ERROR");
    end
    $finish;
  end

endmodule

### pixel_histogram_with_bar_heights.f
sv/phist_pkg.sv
sv/phist_ram.sv
sv/phist_div.sv
sv/pixel_histogram_with_bar_heights.sv
test/testbench.sv
